### rtl/crc_frame_receiver_top_defines.svh
// Assertion macros for the CRC frame receiver.
// Used by crc_frame_receiver_top; expects i_clk and i_rst_n in scope.
`ifndef CRC_FRAME_RECEIVER_TOP_DEFINES_SVH
`define CRC_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define CRCFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crc frame receiver check failed");

// Next-cycle implication, disabled while in reset
`define CRCFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crc frame receiver sequencing check failed");

`endif

### rtl/crcfr_pkg.sv
// Shared constants, status codes and the CRC-16 byte update for the frame receiver.
// No dependencies; used by the channel interfaces and crc_frame_receiver_top.
`timescale 1ns / 1ps

package crcfr_pkg;

    // Frame format
    localparam logic [7:0]  SOF_FIRST    = 8'hA5;
    localparam logic [7:0]  SOF_SECOND   = 8'h5A;
    localparam logic [6:0]  HEADER_BYTES = 7'd8;
    localparam logic [6:0]  MAX_PAYLOAD  = 7'd64;
    localparam int          STORE_DEPTH  = 64;
    localparam int          STORE_AW     = 6;

    // Byte positions within the header
    localparam logic [6:0]  POS_SOF1     = 7'd0;
    localparam logic [6:0]  POS_SOF2     = 7'd1;
    localparam logic [6:0]  POS_VERSION  = 7'd2;
    localparam logic [6:0]  POS_TYPE     = 7'd3;
    localparam logic [6:0]  POS_SEQUENCE = 7'd4;
    localparam logic [6:0]  POS_LEN_LO   = 7'd6;
    localparam logic [6:0]  POS_LEN_HI   = 7'd7;

    // CRC-16, MSB first, no reflection, no final xor
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;

    // Result status codes
    localparam logic [1:0]  STATUS_WAIT   = 2'd0;
    localparam logic [1:0]  STATUS_ACCEPT = 2'd1;
    localparam logic [1:0]  STATUS_ERROR  = 2'd2;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;
    localparam int IDX_W    = 6;

    // One byte through the CRC register, bit by bit
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/crcfr_in_if.sv
// Input byte channel: valid/ready handshake carrying one received byte.
// Depends on crcfr_pkg for the field width.
`timescale 1ns / 1ps

interface crcfr_in_if;
    logic                            valid;
    logic                            ready;
    logic [crcfr_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/crcfr_out_if.sv
// Result channel: valid/ready handshake carrying one status/payload result.
// Depends on crcfr_pkg for the field widths.
`timescale 1ns / 1ps

interface crcfr_out_if;
    logic                              valid;
    logic                              ready;
    logic [crcfr_pkg::STATUS_W-1:0]    status;
    logic [crcfr_pkg::BYTE_W-1:0]      frame_type;
    logic [crcfr_pkg::BYTE_W-1:0]      frame_sequence;
    logic [crcfr_pkg::LEN_W-1:0]       payload_length;
    logic [crcfr_pkg::BYTE_W-1:0]      payload_byte;
    logic [crcfr_pkg::IDX_W-1:0]       payload_index;
    logic                              byte_valid;
    logic                              last;

    modport source (output valid, output status, output frame_type, output frame_sequence,
                    output payload_length, output payload_byte, output payload_index,
                    output byte_valid, output last, input ready);
    modport sink   (input valid, input status, input frame_type, input frame_sequence,
                    input payload_length, input payload_byte, input payload_index,
                    input byte_valid, input last, output ready);
endinterface

### rtl/crc_frame_receiver_top.sv
// Byte-serial frame receiver: start-mark hunt, header check, CRC-16 and payload playback.
// Depends on crcfr_pkg, crcfr_in_if, crcfr_out_if and crc_frame_receiver_top_defines.svh.
`timescale 1ns / 1ps
`include "crc_frame_receiver_top_defines.svh"

// Usage
//   i_in  : one received byte per transfer. Every accepted byte gives at least one
//           result on o_out; each result is registered in the output register.
//   o_out : status 0 (waiting), 2 (error, hunt restarted) or 1 (frame accepted).
//           A good frame with an empty payload gives one result with byte_valid 0;
//           otherwise its payload is replayed from the 64-byte store as one
//           transfer per byte, index 0 upwards, last set on the final byte.
//   i_cfg_we / i_cfg_wdata : protocol version register, write only while idle.
// Throughput: one byte per cycle while receiving and o_out is not stalled. On the
//   final CRC byte of a good frame with a payload the input is held off for the
//   playback; each byte passes through the store's registered read port before
//   the output register.
// Reset: parser back to the hunt, CRC to FFFF, version register to 1, output
//   empty. The payload store is not cleared; only bytes of the current frame
//   are ever read back.
// Stall: when o_out.ready is low with a result waiting, the output register holds
//   it and i_in.ready drops; nothing is lost or repeated.
module crc_frame_receiver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    crcfr_in_if.sink                            i_in,
    crcfr_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [crcfr_pkg::BYTE_W-1:0]        i_cfg_wdata
);

    typedef enum logic {ST_RECV, ST_EMIT} t_state;

    t_state       r_state;
    logic [7:0]   r_proto_ver;
    logic [6:0]   r_byte_count, n_byte_count;
    logic [15:0]  r_crc, n_crc;
    logic [7:0]   r_hdr_version, n_hdr_version;
    logic [7:0]   r_hdr_type, n_hdr_type;
    logic [7:0]   r_hdr_seq, n_hdr_seq;
    logic [15:0]  r_hdr_len, n_hdr_len;
    logic [7:0]   r_crc_low, n_crc_low;

    // Playback counters
    logic [6:0]   r_rd_idx;
    logic [6:0]   r_out_idx;
    logic         r_rd_pend;
    logic [7:0]   r_rd_data;

    // Output register
    logic         r_out_valid;
    logic [1:0]   r_out_status;
    logic [7:0]   r_out_type;
    logic [7:0]   r_out_seq;
    logic [6:0]   r_out_len;
    logic [7:0]   r_out_byte;
    logic [5:0]   r_out_idx_f;
    logic         r_out_bvalid;
    logic         r_out_last;

    // Payload store
    logic [7:0]   mem [crcfr_pkg::STORE_DEPTH];
    logic         mem_we;
    logic [crcfr_pkg::STORE_AW-1:0] mem_waddr;

    logic         slot_free, in_ready, in_acc;
    logic         emit_load, emit_last, rd_en;
    logic [6:0]   emit_len;
    logic         res_load, start_emit;
    logic [1:0]   res_status;
    logic [7:0]   res_type, res_seq;
    logic [6:0]   res_len;
    logic         res_bvalid;
    logic         out_status_ok;

    logic [7:0]   b;
    logic [15:0]  crc_upd;
    logic [6:0]   n_cnt;
    logic [6:0]   pay_off;
    logic [16:0]  p_ext, n_ext, pay_end, frame_end;
    logic         hdr_bad;

    // Handshake
    assign slot_free = !r_out_valid || o_out.ready;
    assign in_ready  = (r_state == ST_RECV) && slot_free;
    assign in_acc    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Playback control
    assign emit_len  = r_hdr_len[6:0];
    assign emit_load = (r_state == ST_EMIT) && r_rd_pend && slot_free;
    assign emit_last = (r_out_idx + 7'd1) == emit_len;
    assign rd_en     = (r_state == ST_EMIT) && (r_rd_idx < emit_len)
                       && (!r_rd_pend || emit_load);

    // Per-byte parser step
    always_comb begin
        b             = i_in.data_byte;
        crc_upd       = crcfr_pkg::crc_step(r_crc, b);
        n_byte_count  = r_byte_count;
        n_crc         = r_crc;
        n_hdr_version = r_hdr_version;
        n_hdr_type    = r_hdr_type;
        n_hdr_seq     = r_hdr_seq;
        n_hdr_len     = r_hdr_len;
        n_crc_low     = r_crc_low;
        mem_we        = 1'b0;
        pay_off       = r_byte_count - crcfr_pkg::HEADER_BYTES;
        mem_waddr     = pay_off[crcfr_pkg::STORE_AW-1:0];
        res_load      = 1'b0;
        start_emit    = 1'b0;
        res_status    = crcfr_pkg::STATUS_WAIT;
        res_type      = 8'h00;
        res_seq       = 8'h00;
        res_len       = 7'd0;
        res_bvalid    = 1'b0;
        n_cnt         = r_byte_count + 7'd1;
        p_ext         = {10'd0, r_byte_count};
        n_ext         = {10'd0, n_cnt};
        pay_end       = 17'd0;
        frame_end     = 17'd0;
        hdr_bad       = 1'b0;

        if (in_acc) begin
            if (r_byte_count == crcfr_pkg::POS_SOF1) begin
                // Hunting for the first start byte
                res_load = 1'b1;
                if (b == crcfr_pkg::SOF_FIRST) begin
                    n_byte_count = 7'd1;
                    n_crc        = crcfr_pkg::CRC_INIT;
                end
            end else if (r_byte_count == crcfr_pkg::POS_SOF2) begin
                // Second start byte; a repeated A5 keeps the hunt one step in
                res_load = 1'b1;
                n_crc    = crcfr_pkg::CRC_INIT;
                if (b == crcfr_pkg::SOF_SECOND) begin
                    n_byte_count = 7'd2;
                end else if (b == crcfr_pkg::SOF_FIRST) begin
                    n_byte_count = 7'd1;
                end else begin
                    n_byte_count = 7'd0;
                end
            end else begin
                pay_end = {10'd0, crcfr_pkg::HEADER_BYTES} + {1'b0, r_hdr_len};
                if (r_byte_count < crcfr_pkg::HEADER_BYTES) begin
                    // Header capture
                    case (r_byte_count)
                        crcfr_pkg::POS_VERSION:  n_hdr_version = b;
                        crcfr_pkg::POS_TYPE:     n_hdr_type    = b;
                        crcfr_pkg::POS_SEQUENCE: n_hdr_seq     = b;
                        crcfr_pkg::POS_LEN_LO:   n_hdr_len     = {8'h00, b};
                        crcfr_pkg::POS_LEN_HI:   n_hdr_len     = {b, r_hdr_len[7:0]};
                        default: ;
                    endcase
                    n_crc = crc_upd;
                end else if (p_ext < pay_end) begin
                    // Payload byte into the store
                    mem_we = 1'b1;
                    n_crc  = crc_upd;
                end else if (p_ext == pay_end) begin
                    n_crc_low = b;
                end

                n_byte_count = n_cnt;
                res_load     = 1'b1;
                frame_end    = {10'd0, crcfr_pkg::HEADER_BYTES} + {1'b0, n_hdr_len} + 17'd2;
                hdr_bad      = (n_hdr_version != r_proto_ver)
                               || (n_hdr_len > {9'd0, crcfr_pkg::MAX_PAYLOAD});

                if (n_cnt < crcfr_pkg::HEADER_BYTES) begin
                    res_status = crcfr_pkg::STATUS_WAIT;
                end else if (hdr_bad) begin
                    res_status   = crcfr_pkg::STATUS_ERROR;
                    n_byte_count = 7'd0;
                    n_crc        = crcfr_pkg::CRC_INIT;
                end else if (n_ext < frame_end) begin
                    res_status = crcfr_pkg::STATUS_WAIT;
                end else begin
                    // Final byte is the CRC high byte
                    n_byte_count = 7'd0;
                    n_crc        = crcfr_pkg::CRC_INIT;
                    if ({b, r_crc_low} != r_crc) begin
                        res_status = crcfr_pkg::STATUS_ERROR;
                    end else if (n_hdr_len == 16'd0) begin
                        res_status = crcfr_pkg::STATUS_ACCEPT;
                        res_type   = n_hdr_type;
                        res_seq    = n_hdr_seq;
                    end else begin
                        res_load   = 1'b0;
                        start_emit = 1'b1;
                    end
                end
            end
        end
    end

    // Payload store write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= b;
        end
    end

    // Payload store read port, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_rd_idx[crcfr_pkg::STORE_AW-1:0]];
        end
    end

    // Control state, parser registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_RECV;
            r_proto_ver   <= 8'd1;
            r_byte_count  <= 7'd0;
            r_crc         <= crcfr_pkg::CRC_INIT;
            r_hdr_version <= 8'h00;
            r_hdr_type    <= 8'h00;
            r_hdr_seq     <= 8'h00;
            r_hdr_len     <= 16'h0000;
            r_crc_low     <= 8'h00;
            r_rd_idx      <= 7'd0;
            r_out_idx     <= 7'd0;
            r_rd_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_proto_ver <= i_cfg_wdata;
            end
            r_byte_count  <= n_byte_count;
            r_crc         <= n_crc;
            r_hdr_version <= n_hdr_version;
            r_hdr_type    <= n_hdr_type;
            r_hdr_seq     <= n_hdr_seq;
            r_hdr_len     <= n_hdr_len;
            r_crc_low     <= n_crc_low;

            case (r_state)
                ST_RECV: begin
                    if (start_emit) begin
                        r_state   <= ST_EMIT;
                        r_rd_idx  <= 7'd0;
                        r_out_idx <= 7'd0;
                        r_rd_pend <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (rd_en) begin
                        r_rd_idx  <= r_rd_idx + 7'd1;
                        r_rd_pend <= 1'b1;
                    end else if (emit_load) begin
                        r_rd_pend <= 1'b0;
                    end
                    if (emit_load) begin
                        r_out_idx <= r_out_idx + 7'd1;
                        if (emit_last) begin
                            r_state <= ST_RECV;
                        end
                    end
                end
                default: r_state <= ST_RECV;
            endcase

            if (res_load || emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // Output payload
            if (emit_load) begin
                r_out_status <= crcfr_pkg::STATUS_ACCEPT;
                r_out_type   <= r_hdr_type;
                r_out_seq    <= r_hdr_seq;
                r_out_len    <= emit_len;
                r_out_byte   <= r_rd_data;
                r_out_idx_f  <= r_out_idx[crcfr_pkg::IDX_W-1:0];
                r_out_bvalid <= 1'b1;
                r_out_last   <= emit_last;
            end else if (res_load) begin
                r_out_status <= res_status;
                r_out_type   <= res_type;
                r_out_seq    <= res_seq;
                r_out_len    <= res_len;
                r_out_byte   <= 8'h00;
                r_out_idx_f  <= 6'd0;
                r_out_bvalid <= res_bvalid;
                r_out_last   <= 1'b1;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.frame_type     = r_out_type;
    assign o_out.frame_sequence = r_out_seq;
    assign o_out.payload_length = r_out_len;
    assign o_out.payload_byte   = r_out_byte;
    assign o_out.payload_index  = r_out_idx_f;
    assign o_out.byte_valid     = r_out_bvalid;
    assign o_out.last           = r_out_last;

    // Checks
    assign out_status_ok = r_out_status inside {crcfr_pkg::STATUS_WAIT,
                                                crcfr_pkg::STATUS_ACCEPT,
                                                crcfr_pkg::STATUS_ERROR};

    `CRCFR_ASSERT_NOW(a_pend_only_in_emit, r_rd_pend, r_state == ST_EMIT)
    `CRCFR_ASSERT_NOW(a_store_write_in_recv, mem_we, r_state == ST_RECV)
    `CRCFR_ASSERT_NOW(a_read_ahead_order, r_state == ST_EMIT, r_out_idx <= r_rd_idx)
    `CRCFR_ASSERT_NEXT(a_last_ends_playback, emit_load && emit_last, r_state == ST_RECV && r_out_valid)
    `CRCFR_ASSERT_NOW(a_status_code, r_out_valid, out_status_ok)

endmodule

### tb/tb_top.sv
// Self-checking bench for crc_frame_receiver_top: framed byte streams in, results checked out.
// Depends on crcfr_pkg, crcfr_in_if, crcfr_out_if and the receiver RTL.
`timescale 1ns / 1ps

module tb_top;
    import crcfr_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 80;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   frame_type;
        logic [BYTE_W-1:0]   frame_sequence;
        logic [LEN_W-1:0]    payload_length;
        logic [BYTE_W-1:0]   payload_byte;
        logic [IDX_W-1:0]    payload_index;
        logic                byte_valid;
        logic                last;
    } t_rx_result;

    typedef enum {
        FRM_GOOD,
        FRM_BAD_VERSION,
        FRM_BAD_LENGTH,
        FRM_BAD_CRC,
        FRM_CUT,
        FRM_NOISE,
        FRM_FALSE_START
    } t_frame_kind;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [BYTE_W-1:0] cfg_wdata;

    crcfr_in_if  in_if ();
    crcfr_out_if out_if ();

    crc_frame_receiver_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Stimulus and expectation stores
    logic [BYTE_W-1:0] pending_bytes[$];
    t_rx_result        expected_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req_cnt;
    int hold_served_cnt = 0;
    int hold_left       = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // Receiver model state
    logic [6:0]        rx_pos       = POS_SOF1;
    logic [15:0]       rx_crc       = CRC_INIT;
    logic [BYTE_W-1:0] hdr_version  = '0;
    logic [BYTE_W-1:0] hdr_type     = '0;
    logic [BYTE_W-1:0] hdr_sequence = '0;
    logic [15:0]       hdr_length   = '0;
    logic [BYTE_W-1:0] crc_low      = '0;
    logic [BYTE_W-1:0] payload_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] version_reg;

    // CRC-16/CCITT, one data bit at a time, MSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void push_status(input logic [STATUS_W-1:0] s);
        t_rx_result r;
        r        = '0;
        r.status = s;
        r.last   = 1'b1;
        expected_results.push_back(r);
    endfunction

    function automatic void restart_hunt();
        rx_pos = POS_SOF1;
        rx_crc = CRC_INIT;
    endfunction

    // Work out the results caused by one received byte
    function automatic void predict_rx_byte(input logic [BYTE_W-1:0] b);
        int         pos;
        int         fill;
        int         len;
        int         k;
        t_rx_result r;
        pos = int'(rx_pos);
        len = int'(hdr_length);
        if (rx_pos == POS_SOF1) begin
            if (b == SOF_FIRST) begin
                rx_pos = POS_SOF2;
                rx_crc = CRC_INIT;
            end
            push_status(STATUS_WAIT);
            return;
        end
        // a second A5 counts as a fresh first start byte
        if (rx_pos == POS_SOF2) begin
            if (b == SOF_SECOND) begin
                rx_pos = POS_VERSION;
            end else if (b == SOF_FIRST) begin
                rx_pos = POS_SOF2;
            end else begin
                rx_pos = POS_SOF1;
            end
            rx_crc = CRC_INIT;
            push_status(STATUS_WAIT);
            return;
        end

        // header, payload, then the low CRC byte
        if (pos < int'(HEADER_BYTES)) begin
            case (rx_pos)
                POS_VERSION:  hdr_version = b;
                POS_TYPE:     hdr_type = b;
                POS_SEQUENCE: hdr_sequence = b;
                POS_LEN_LO:   hdr_length = {8'h00, b};
                POS_LEN_HI:   hdr_length[15:8] = b;
                default: ;
            endcase
            rx_crc = crc16_next(rx_crc, b);
        end else if (pos < int'(HEADER_BYTES) + len) begin
            payload_mem[(pos - int'(HEADER_BYTES)) % STORE_DEPTH] = b;
            rx_crc = crc16_next(rx_crc, b);
        end else if (pos == int'(HEADER_BYTES) + len) begin
            crc_low = b;
        end

        fill   = pos + 1;
        rx_pos = 7'(fill);
        len    = int'(hdr_length);
        if (fill < int'(HEADER_BYTES)) begin
            push_status(STATUS_WAIT);
        end else if (hdr_version != version_reg || hdr_length > MAX_PAYLOAD) begin
            restart_hunt();
            push_status(STATUS_ERROR);
        end else if (fill < int'(HEADER_BYTES) + len + 2) begin
            push_status(STATUS_WAIT);
        end else if ({b, crc_low} != rx_crc) begin
            restart_hunt();
            push_status(STATUS_ERROR);
        end else begin
            restart_hunt();
            r                = '0;
            r.status         = STATUS_ACCEPT;
            r.frame_type     = hdr_type;
            r.frame_sequence = hdr_sequence;
            if (len == 0) begin
                r.last = 1'b1;
                expected_results.push_back(r);
            end else begin
                for (k = 0; k < len; k++) begin
                    r.payload_length = LEN_W'(len);
                    r.payload_byte   = payload_mem[k];
                    r.payload_index  = IDX_W'(k);
                    r.byte_valid     = 1'b1;
                    r.last           = (k == len - 1);
                    expected_results.push_back(r);
                end
            end
        end
    endfunction

    // Build one byte sequence of the given kind and queue it for the driver
    function automatic int queue_frame(input t_frame_kind kind, input int len);
        logic [BYTE_W-1:0] frm[$];
        logic [BYTE_W-1:0] version;
        logic [BYTE_W-1:0] nb;
        logic [15:0]       len_field;
        logic [15:0]       crc;
        int                idx;
        int                cut;
        version   = version_reg;
        len_field = 16'(len);
        case (kind)
            FRM_NOISE: begin
                repeat ($urandom_range(6, 1)) frm.push_back(BYTE_W'($urandom));
            end
            FRM_FALSE_START: begin
                frm.push_back(SOF_FIRST);
                do nb = BYTE_W'($urandom); while (nb == SOF_SECOND);
                frm.push_back($urandom_range(1) ? SOF_FIRST : nb);
            end
            default: begin
                if (kind == FRM_BAD_VERSION) begin
                    version = version_reg ^ BYTE_W'($urandom_range(255, 1));
                end
                if (kind == FRM_BAD_LENGTH) begin
                    len_field = $urandom_range(1) ? 16'($urandom_range(255, 65))
                                                  : 16'($urandom_range(65535, 256));
                end
                frm.push_back(SOF_FIRST);
                frm.push_back(SOF_SECOND);
                frm.push_back(version);
                repeat (3) frm.push_back(BYTE_W'($urandom));
                frm.push_back(len_field[7:0]);
                frm.push_back(len_field[15:8]);
                // a bad header is rejected as soon as it is complete
                if (kind != FRM_BAD_VERSION && kind != FRM_BAD_LENGTH) begin
                    repeat (len) frm.push_back(BYTE_W'($urandom));
                    crc = CRC_INIT;
                    for (int k = 2; k < frm.size(); k++) begin
                        crc = crc16_next(crc, frm[k]);
                    end
                    frm.push_back(crc[7:0]);
                    frm.push_back(crc[15:8]);
                    if (kind == FRM_BAD_CRC) begin
                        idx      = frm.size() - 1 - $urandom_range(1);
                        frm[idx] = frm[idx] ^ BYTE_W'($urandom_range(255, 1));
                    end
                    if (kind == FRM_CUT) begin
                        cut = $urandom_range(frm.size() - 1, 3);
                        while (frm.size() > cut) frm.delete(frm.size() - 1);
                    end
                end
            end
        endcase
        foreach (frm[k]) pending_bytes.push_back(frm[k]);
        return frm.size();
    endfunction

    // Mostly good frames with random content, the rest broken or noise
    function automatic void queue_random(input int budget);
        int          queued;
        int          r;
        int          len;
        t_frame_kind kind;
        queued = 0;
        while (queued < budget) begin
            r = $urandom_range(99);
            if (r < 70)      kind = FRM_GOOD;
            else if (r < 76) kind = FRM_BAD_CRC;
            else if (r < 80) kind = FRM_BAD_VERSION;
            else if (r < 84) kind = FRM_BAD_LENGTH;
            else if (r < 90) kind = FRM_CUT;
            else if (r < 95) kind = FRM_NOISE;
            else             kind = FRM_FALSE_START;
            r = $urandom_range(99);
            if (r == 99)     len = int'(MAX_PAYLOAD);
            else if (r < 75) len = $urandom_range(8, 0);
            else if (r < 92) len = $urandom_range(31, 9);
            else             len = $urandom_range(64, 32);
            // keep cut frames short so the hunt recovers quickly
            if (kind == FRM_CUT) begin
                len = len % 9;
            end
            queued += queue_frame(kind, len);
        end
    endfunction

    function automatic string fmt_result(input t_rx_result r);
        return $sformatf("st=%0d ty=%02h sq=%02h len=%0d pb=%02h ix=%0d bv=%0b last=%0b",
                         r.status, r.frame_type, r.frame_sequence, r.payload_length,
                         r.payload_byte, r.payload_index, r.byte_valid, r.last);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_result();
        t_rx_result got;
        t_rx_result want;
        got.status         = out_if.status;
        got.frame_type     = out_if.frame_type;
        got.frame_sequence = out_if.frame_sequence;
        got.payload_length = out_if.payload_length;
        got.payload_byte   = out_if.payload_byte;
        got.payload_index  = out_if.payload_index;
        got.byte_valid     = out_if.byte_valid;
        got.last           = out_if.last;
        if (expected_results.size() == 0) begin
            report_mismatch({"result with nothing expected: ", fmt_result(got)});
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                report_mismatch({"got ", fmt_result(got), " expected ", fmt_result(want)});
            end
        end
    endtask

    task automatic write_version(input logic [BYTE_W-1:0] v);
        repeat (SETTLE) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        version_reg = v;
    endtask

    // Sender stopped and every expected result delivered
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_if.valid || expected_results.size() != 0);
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] v, input int idle_pct,
                             input int stall_pct, input int budget);
        write_version(v);
        @(negedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random(budget);
        wait_drained();
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Byte driver: one transfer per accepted item, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_if.valid     <= 1'b1;
                in_if.data_byte <= pending_bytes.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_served_cnt != hold_req_cnt) begin
            hold_served_cnt = hold_req_cnt;
            hold_left       = LONG_HOLD;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input transfers, check on output transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                predict_rx_byte(in_if.data_byte);
            end
            if (out_if.valid && out_if.ready) begin
                check_result();
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        i_rst_n         = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req_cnt    = 0;
        version_reg     = 8'd1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, bad second start byte, repeated A5, empty frame,
        // oversized length, wrong version, CRC error, full-size payload
        write_version(8'd1);
        @(negedge i_clk);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(SOF_FIRST);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(SOF_FIRST);
        void'(queue_frame(FRM_GOOD, 0));
        void'(queue_frame(FRM_BAD_LENGTH, 0));
        void'(queue_frame(FRM_BAD_VERSION, 0));
        void'(queue_frame(FRM_BAD_CRC, 2));
        void'(queue_frame(FRM_GOOD, int'(MAX_PAYLOAD)));
        queue_random(20);
        wait_drained();

        // Random phases across version settings and idling patterns
        run_phase(8'd0, 87, 0, 70);
        run_phase(8'd255, 0, 87, 70);
        run_phase(BYTE_W'($urandom_range(254, 2)), 20, 20, 70);

        // Back-pressure: long sink hold-off while bytes keep coming, then a full drain
        write_version(8'd1);
        @(negedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(45);
        hold_req_cnt++;
        wait_drained();
        queue_random(45);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
